// File: rtl/lrt_pkg.sv
// Shared types and constants for the label remap table.
package lrt_pkg;

    // Width of the label fields on the word channels.
    localparam int PORT_LABEL_BITS = 64;

    // Defaults for the top-level parameters.
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int LABEL_BITS_DEF    = 64;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

endpackage

// File: rtl/lrt_ifs.sv
// Request and response channel interfaces of the label remap table.
interface lrt_req_if;
    logic                                valid;
    logic                                ready;
    lrt_pkg::opcode_t                    opcode;
    logic [lrt_pkg::PORT_LABEL_BITS-1:0] source_label;
    logic [lrt_pkg::PORT_LABEL_BITS-1:0] target_label;

    modport source (output valid, output opcode, output source_label, output target_label,
                    input ready);
    modport sink   (input valid, input opcode, input source_label, input target_label,
                    output ready);
endinterface

interface lrt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lrt_pkg::PORT_LABEL_BITS-1:0] result_label;
    logic                                found;
    logic                                table_full;

    modport source (output valid, output result_label, output found, output table_full,
                    input ready);
    modport sink   (input valid, input result_label, input found, input table_full,
                    output ready);
endinterface

// File: rtl/lrt_ram.sv
// Generic simple dual-port RAM with registered read data.
module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/label_remap_table_top.sv
// Top level of the label remap table: hashed open-addressing table in one RAM.
//
// The table maps labels to replacement labels. It lives in a single RAM of
// TABLE_ENTRIES words of {valid, key, value}, addressed by an XOR fold of the
// key and searched by linear probing, one slot per cycle on the RAM read port.
// After reset a clearing pass writes every word once, during which no request
// word is taken. A lookup searches the source key's chain; an insert is a
// target lookup, then a source probe and write-back. With the table full and
// a new key, the probe visits every slot. One request is in work at a time;
// a finished response sits in an output register, and the next request is
// taken while it waits.
module label_remap_table_top #(
    parameter int TABLE_ENTRIES = lrt_pkg::TABLE_ENTRIES_DEF,
    parameter int LABEL_BITS    = lrt_pkg::LABEL_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    lrt_req_if.sink   req,
    lrt_rsp_if.source rsp
);

    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ENTRY_W = 1 + 2 * LABEL_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_FINISH
    } state_t;

    typedef enum logic {
        PH_TARGET,
        PH_SOURCE
    } phase_t;

    // XOR fold of the key onto the index, then one conditional subtract so
    // that a table size that is not a power of two stays in range.
    function automatic logic [IDX_W-1:0] slot_hash(input logic [LABEL_BITS-1:0] key);
        logic [IDX_W-1:0] h;
        logic [IDX_W:0]   ext;
        h = '0;
        for (int i = 0; i < LABEL_BITS; i++)
        begin
            h[i % IDX_W] = h[i % IDX_W] ^ key[i];
        end
        ext = {1'b0, h};
        if (ext >= (IDX_W+1)'(TABLE_ENTRIES))
        begin
            ext = ext - (IDX_W+1)'(TABLE_ENTRIES);
        end
        return ext[IDX_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    lrt_pkg::opcode_t      op_reg, op_next;
    logic [LABEL_BITS-1:0] src_reg, src_next;
    logic [LABEL_BITS-1:0] tgt_reg, tgt_next;
    logic [LABEL_BITS-1:0] res_reg, res_next;
    logic                  found_reg, found_next;
    logic                  full_reg, full_next;
    logic [IDX_W-1:0]      probe_addr_reg, probe_addr_next;
    logic [IDX_W-1:0]      probe_cnt_reg, probe_cnt_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LABEL_BITS-1:0] out_label_reg, out_label_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_full_reg, out_full_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [LABEL_BITS-1:0] req_src;
    logic [LABEL_BITS-1:0] req_tgt;
    logic [IDX_W-1:0]      hash_req_src;
    logic [IDX_W-1:0]      hash_req_tgt;
    logic [IDX_W-1:0]      hash_src;
    logic [IDX_W-1:0]      probe_inc;
    logic [LABEL_BITS-1:0] cur_key;
    logic                  ent_valid;
    logic [LABEL_BITS-1:0] ent_key;
    logic [LABEL_BITS-1:0] ent_val;
    logic                  ent_hit;
    logic                  ent_empty;
    logic                  probe_last;
    logic                  out_free;

    lrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_src      = req.source_label[LABEL_BITS-1:0];
    assign req_tgt      = req.target_label[LABEL_BITS-1:0];
    assign hash_req_src = slot_hash(req_src);
    assign hash_req_tgt = slot_hash(req_tgt);
    assign hash_src     = slot_hash(src_reg);

    assign probe_inc  = (probe_addr_reg == IDX_W'(TABLE_ENTRIES - 1)) ? '0
                                                                      : probe_addr_reg + 1'b1;
    assign probe_last = (probe_cnt_reg == IDX_W'(TABLE_ENTRIES - 1));

    assign cur_key   = (phase_reg == PH_TARGET) ? tgt_reg : src_reg;
    assign ent_valid = ram_rdata[ENTRY_W-1];
    assign ent_key   = ram_rdata[2*LABEL_BITS-1:LABEL_BITS];
    assign ent_val   = ram_rdata[LABEL_BITS-1:0];
    assign ent_hit   = ent_valid && (ent_key == cur_key);
    assign ent_empty = !ent_valid;

    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_label = lrt_pkg::PORT_LABEL_BITS'(out_label_reg);
    assign rsp.found        = out_found_reg;
    assign rsp.table_full   = out_full_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        op_next         = op_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        res_next        = res_reg;
        found_next      = found_reg;
        full_next       = full_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_label_next  = out_label_reg;
        out_found_next  = out_found_reg;
        out_full_next   = out_full_reg;

        ram_we    = 1'b0;
        ram_waddr = probe_addr_reg;
        ram_wdata = {1'b1, src_reg, res_reg};
        ram_re    = 1'b0;
        ram_raddr = probe_inc;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.opcode;
                    src_next       = req_src;
                    tgt_next       = req_tgt;
                    full_next      = 1'b0;
                    probe_cnt_next = '0;
                    ram_re         = 1'b1;
                    state_next     = ST_PROBE;
                    if (req.opcode == lrt_pkg::OP_LOOKUP)
                    begin
                        phase_next      = PH_SOURCE;
                        ram_raddr       = hash_req_src;
                        probe_addr_next = hash_req_src;
                    end
                    else
                    begin
                        phase_next      = PH_TARGET;
                        ram_raddr       = hash_req_tgt;
                        probe_addr_next = hash_req_tgt;
                    end
                end
            end

            ST_PROBE:
            begin
                // Read of the next slot goes out speculatively each cycle.
                ram_re          = 1'b1;
                probe_addr_next = probe_inc;
                probe_cnt_next  = probe_cnt_reg + 1'b1;
                if (phase_reg == PH_TARGET)
                begin
                    if (ent_hit || ent_empty || probe_last)
                    begin
                        res_next        = ent_hit ? ent_val : tgt_reg;
                        found_next      = ent_hit;
                        phase_next      = PH_SOURCE;
                        ram_raddr       = hash_src;
                        probe_addr_next = hash_src;
                        probe_cnt_next  = '0;
                    end
                end
                else if (op_reg == lrt_pkg::OP_LOOKUP)
                begin
                    if (ent_hit || ent_empty || probe_last)
                    begin
                        res_next   = ent_hit ? ent_val : src_reg;
                        found_next = ent_hit;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    // No deletions, so a key is always met before a free slot.
                    if (ent_hit || ent_empty)
                    begin
                        ram_we     = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else if (probe_last)
                    begin
                        full_next  = 1'b1;
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_label_next = res_reg;
                    out_found_next = found_reg;
                    out_full_next  = full_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            phase_reg      <= PH_TARGET;
            op_reg         <= lrt_pkg::OP_INSERT;
            src_reg        <= '0;
            tgt_reg        <= '0;
            res_reg        <= '0;
            found_reg      <= 1'b0;
            full_reg       <= 1'b0;
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_label_reg  <= '0;
            out_found_reg  <= 1'b0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            op_reg         <= op_next;
            src_reg        <= src_next;
            tgt_reg        <= tgt_next;
            res_reg        <= res_next;
            found_reg      <= found_next;
            full_reg       <= full_next;
            probe_addr_reg <= probe_addr_next;
            probe_cnt_reg  <= probe_cnt_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            out_label_reg  <= out_label_next;
            out_found_reg  <= out_found_next;
            out_full_reg   <= out_full_next;
        end
    end

`ifndef ASSERT_OFF
    // Outside the clearing pass only live entries are ever written.
    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> ram_wdata[ENTRY_W-1])
        else $error("table write outside clearing pass without valid bit");

    // No request word is taken while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request accepted during clearing pass");

    // A finished result lands in the output register and the block goes idle.
    a_finish_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("finished result not loaded into output register");

    // table_full comes only from an insert that wrote nothing.
    a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && full_next && !full_reg) |-> !ram_we)
        else $error("dropped insert wrote the table");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for label_remap_table_top: directed rows, then a random mix that fills the table.
module tb;

    localparam int TABLE_ENTRIES = lrt_pkg::TABLE_ENTRIES_DEF;
    localparam int LABEL_BITS    = lrt_pkg::LABEL_BITS_DEF;

    typedef logic [lrt_pkg::PORT_LABEL_BITS-1:0] label_t;

    localparam label_t LABEL_MASK = (LABEL_BITS >= lrt_pkg::PORT_LABEL_BITS) ? '1 :
                                    ((label_t'(1) << LABEL_BITS) - label_t'(1));
    localparam label_t ALL_ONES   = '1;
    localparam label_t ALT_A      = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam label_t ALT_5      = 64'h5555_5555_5555_5555;
    localparam label_t TOP_BIT    = 64'h8000_0000_0000_0000;

    localparam int DIRECTED_COUNT = 23;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int QUIET_ITEMS    = 200;
    // worst insert, both idle bursts, per item; clearing pass on top; then 4x margin
    localparam longint CYCLE_LIMIT = 4 * (longint'(DIRECTED_COUNT + RANDOM_ITEMS) *
                                          (2 * TABLE_ENTRIES + 2 + 24) + TABLE_ENTRIES + 7);

    typedef struct packed {
        label_t label;
        logic   found;
        logic   full;
    } remap_result_t;

    typedef struct packed {
        lrt_pkg::opcode_t op;
        label_t           src;
        label_t           tgt;
        logic             typed;
        label_t           label;
        logic             found;
        logic             full;
    } stim_row_t;

    // typed == 1: expected word given here; otherwise taken from the predictor
    localparam stim_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        '{lrt_pkg::OP_LOOKUP, 64'd0,    ALL_ONES, 1'b1, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, ALL_ONES, 64'd0,    1'b1, ALL_ONES, 1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd5,    64'd7,    1'b1, 64'd7,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd5,    64'd0,    1'b1, 64'd7,    1'b1, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd9,    64'd5,    1'b1, 64'd7,    1'b1, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd9,    ALL_ONES, 1'b1, 64'd7,    1'b1, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd9,    64'd9,    1'b1, 64'd7,    1'b1, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd5,    64'd11,   1'b1, 64'd11,   1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd5,    64'd0,    1'b1, 64'd11,   1'b1, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd5,    64'd9,    1'b0, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, ALL_ONES, 64'd0,    1'b1, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd0,    ALL_ONES, 1'b1, 64'd0,    1'b1, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd0,    64'd0,    1'b1, 64'd0,    1'b1, 1'b0},
        '{lrt_pkg::OP_LOOKUP, ALL_ONES, ALL_ONES, 1'b1, 64'd0,    1'b1, 1'b0},
        '{lrt_pkg::OP_INSERT, ALT_A,    ALT_5,    1'b0, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, ALT_5,    ALT_A,    1'b0, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, ALT_5,    ALT_A,    1'b0, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, ALT_A,    ALT_5,    1'b0, 64'd0,    1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, TOP_BIT,  64'd1,    1'b1, 64'd1,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, TOP_BIT,  64'd0,    1'b1, 64'd1,    1'b1, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd1,    TOP_BIT,  1'b1, 64'd1,    1'b0, 1'b0},
        '{lrt_pkg::OP_INSERT, 64'd1,    64'd1,    1'b1, 64'd1,    1'b0, 1'b0},
        '{lrt_pkg::OP_LOOKUP, 64'd1,    64'd0,    1'b1, 64'd1,    1'b1, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    lrt_req_if req_ch ();
    lrt_rsp_if rsp_ch ();

    label_remap_table_top #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LABEL_BITS    (LABEL_BITS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    label_t        remap_table [label_t];
    label_t        known_keys [$];
    remap_result_t expected_words [$];
    int            mismatch_count = 0;
    longint        cycle_count    = 0;
    int            idle_pct       = 0;
    int            stall_left     = 0;

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    endtask

    // Table behavior as seen from the ports; slot placement is not visible.
    function automatic remap_result_t resolve_word(input lrt_pkg::opcode_t op,
                                                   input label_t src_in,
                                                   input label_t tgt_in);
        remap_result_t r;
        label_t        src;
        label_t        tgt;
        src = src_in & LABEL_MASK;
        tgt = tgt_in & LABEL_MASK;
        r   = '0;
        if (op == lrt_pkg::OP_LOOKUP)
        begin
            if (remap_table.exists(src))
            begin
                r.label = remap_table[src];
                r.found = 1'b1;
            end
            else
                r.label = src;
        end
        else
        begin
            if (remap_table.exists(tgt))
            begin
                r.label = remap_table[tgt];
                r.found = 1'b1;
            end
            else
                r.label = tgt;
            if (remap_table.exists(src))
                remap_table[src] = r.label;
            else if (remap_table.num() < TABLE_ENTRIES)
            begin
                remap_table[src] = r.label;
                known_keys.insert(known_keys.size(), src);
            end
            else
                r.full = 1'b1;
        end
        r.label &= LABEL_MASK;
        return r;
    endfunction

    function automatic label_t random_label();
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic label_t pick_known();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    task automatic maybe_idle();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_word(input lrt_pkg::opcode_t op, input label_t src, input label_t tgt,
                             input logic typed, input remap_result_t typed_word);
        remap_result_t predicted;
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.source_label <= src;
        req_ch.target_label <= tgt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = resolve_word(op, src, tgt);
        expected_words.insert(expected_words.size(), typed ? typed_word : predicted);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= (stall_left == 1);
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left   <= $urandom_range(1, 12);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_words
        remap_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("response word with nothing outstanding");
            else
            begin
                want = expected_words.pop_front();
                if (rsp_ch.result_label !== want.label)
                    report_mismatch($sformatf("result_label %h, want %h",
                                              rsp_ch.result_label, want.label));
                if (rsp_ch.found !== want.found)
                    report_mismatch($sformatf("found %b, want %b", rsp_ch.found, want.found));
                if (rsp_ch.table_full !== want.full)
                    report_mismatch($sformatf("table_full %b, want %b",
                                              rsp_ch.table_full, want.full));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t        row;
        remap_result_t    typed_word;
        lrt_pkg::opcode_t op;
        label_t           src;
        label_t           tgt;
        logic             is_full;
        int               i;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.opcode       <= lrt_pkg::OP_INSERT;
        req_ch.source_label <= '0;
        req_ch.target_label <= '0;
        repeat (7) @(posedge clk);
        rst_n    <= 1'b1;
        idle_pct = 25;

        for (i = 0; i < DIRECTED_COUNT; i++)
        begin
            row        = DIRECTED_ROWS[i];
            typed_word = '{label: row.label, found: row.found, full: row.full};
            maybe_idle();
            send_word(row.op, row.src, row.tgt, row.typed, typed_word);
        end

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 20;
                    default: idle_pct = 50;
                endcase
            end
            if (i >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_pct = 0;
            // fill the table fast, then mostly revisit keys so a full table stays cheap
            is_full = (remap_table.num() >= TABLE_ENTRIES);
            op = ($urandom_range(0, 99) < 85) ? lrt_pkg::OP_INSERT : lrt_pkg::OP_LOOKUP;
            if (op == lrt_pkg::OP_INSERT)
            begin
                src = ($urandom_range(0, 7) < (is_full ? 1 : 7)) ? random_label() : pick_known();
                tgt = ($urandom_range(0, 7) < (is_full ? 1 : 4)) ? random_label() : pick_known();
            end
            else
            begin
                src = ($urandom_range(0, 3) == 0) ? random_label() : pick_known();
                tgt = random_label();
            end
            maybe_idle();
            send_word(op, src, tgt, 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        // catch any stray word after the last expected one
        repeat (2 * TABLE_ENTRIES + 16) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lrt_pkg.sv
rtl/lrt_ifs.sv
rtl/lrt_ram.sv
rtl/label_remap_table_top.sv
tb/tb.sv
